@@ design/ean13_pkg.sv @@
package ean13_pkg;

  localparam int unsigned BinW      = 40;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 12;
  localparam int unsigned BcdW      = DigitW * NumDigits;
  localparam int unsigned BitCntW   = $clog2(BinW);
  localparam int unsigned GroupW    = 7;
  localparam int unsigned MaskW     = 6;
  localparam int unsigned StepW     = 4;

  localparam logic [MaskW-1:0]  MaskReset   = 6'd28;
  localparam logic [GroupW-1:0] GuardEdge   = 7'd5;
  localparam logic [GroupW-1:0] GuardCentre = 7'd10;
  localparam logic [GroupW-1:0] RInvert     = 7'h7F;

  // emit and check steps that carry a fixed group, a special digit or a boundary
  localparam logic [StepW-1:0] StepStart  = 4'd0;
  localparam logic [StepW-1:0] StepLeftHi = 4'd6;
  localparam logic [StepW-1:0] StepCentre = 4'd7;
  localparam logic [StepW-1:0] StepCheck  = 4'd13;
  localparam logic [StepW-1:0] StepEnd    = 4'd14;
  localparam logic [StepW-1:0] StepLastDigit = 4'd11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic rotate;
    logic accum;
  } ring_ctrl_t;

  function automatic logic [GroupW-1:0] code_l(input logic [DigitW-1:0] d);
    logic [GroupW-1:0] v;
    unique case (d)
      4'd0:    v = 7'h0D;
      4'd1:    v = 7'h19;
      4'd2:    v = 7'h13;
      4'd3:    v = 7'h3D;
      4'd4:    v = 7'h23;
      4'd5:    v = 7'h31;
      4'd6:    v = 7'h2F;
      4'd7:    v = 7'h3B;
      4'd8:    v = 7'h37;
      4'd9:    v = 7'h0B;
      default: v = 7'h0D;
    endcase
    return v;
  endfunction

  function automatic logic [GroupW-1:0] code_g(input logic [DigitW-1:0] d);
    logic [GroupW-1:0] v;
    unique case (d)
      4'd0:    v = 7'h27;
      4'd1:    v = 7'h33;
      4'd2:    v = 7'h1B;
      4'd3:    v = 7'h21;
      4'd4:    v = 7'h1D;
      4'd5:    v = 7'h39;
      4'd6:    v = 7'h05;
      4'd7:    v = 7'h11;
      4'd8:    v = 7'h09;
      4'd9:    v = 7'h17;
      default: v = 7'h27;
    endcase
    return v;
  endfunction

endpackage

@@ design/ean13_bcd_conv.sv @@
module ean13_bcd_conv import ean13_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BinW-1:0]   value_i,
  output logic              done_o,
  output logic [BcdW-1:0]   digits_o
);

  logic [BinW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BcdW-1:0]    adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i*DigitW +: DigitW] = (bcd_q[i*DigitW +: DigitW] >= 4'd5) ?
                                bcd_q[i*DigitW +: DigitW] + 4'd3 :
                                bcd_q[i*DigitW +: DigitW];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // digits above the twelfth fall off the top
      bcd_d = {adj[BcdW-2:0], bin_q[BinW-1]};
      bin_d = {bin_q[BinW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BitCntW'(BinW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

@@ design/ean13_digit_ring.sv @@
module ean13_digit_ring import ean13_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_ctrl_t        ctrl_i,
  input  logic [BcdW-1:0]   digits_i,
  output logic [DigitW-1:0] head_o,
  output logic [DigitW-1:0] check_o
);

  logic [BcdW-1:0]   ring_q, ring_d;
  logic [DigitW-1:0] acc_q, acc_d;
  logic              w3_q, w3_d;
  logic [DigitW-1:0] head;
  logic [4:0]        term;
  logic [5:0]        sum;

  assign head = ring_q[BcdW-1 -: DigitW];
  assign term = w3_q ? (5'(head) + {head, 1'b0}) : 5'(head);
  assign sum  = 6'(acc_q) + 6'(term);

  always_comb begin
    ring_d = ring_q;
    acc_d  = acc_q;
    w3_d   = w3_q;
    if (ctrl_i.load) begin
      ring_d = digits_i;
      acc_d  = '0;
      w3_d   = 1'b0;
    end else begin
      if (ctrl_i.rotate) begin
        ring_d = {ring_q[BcdW-DigitW-1:0], head};
      end
      if (ctrl_i.accum) begin
        w3_d = !w3_q;
        // keep the weighted sum reduced mod ten
        priority if (sum >= 6'd30) acc_d = 4'(sum - 6'd30);
        else if (sum >= 6'd20)      acc_d = 4'(sum - 6'd20);
        else if (sum >= 6'd10)      acc_d = 4'(sum - 6'd10);
        else                        acc_d = 4'(sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      w3_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      w3_q  <= w3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
  end

  assign head_o  = head;
  assign check_o = (acc_q == '0) ? '0 : 4'd10 - acc_q;

endmodule

@@ design/ean13_module_encoder_core.sv @@
// Channel   Dir  Handshake                  Payload
// in        in   in_valid_i / in_stall_o    raw_number_i [39:0]
// out       out  out_valid_o / out_stall_i  modules_o [6:0]
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_left_parity_mask_i [5:0]
//
// One word passes through these steps: accept, bit-serial binary to BCD
// conversion (one input bit per cycle), load the digit ring, walk the 12
// digits for the check digit, and emit the 15 groups, one group per emit
// step, with a step held while the output stalls.
// Reset clears the control state and sets the parity mask to 011100 (LGGGLL).
// in_stall_o is high from acceptance until the last group is loaded into the
// output register; the output register holds a valid group while out_stall_i is high.
module ean13_module_encoder_core import ean13_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BinW-1:0]   raw_number_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [GroupW-1:0] modules_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [MaskW-1:0]  cfg_left_parity_mask_i
);

  state_e             state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [MaskW-1:0]   mask_q;
  logic               out_valid_q, out_valid_d;
  logic [GroupW-1:0]  modules_q, modules_d;

  logic               in_accept;
  logic               conv_done;
  logic [BcdW-1:0]    conv_digits;
  ring_ctrl_t         ring_ctrl;
  logic [DigitW-1:0]  head;
  logic [DigitW-1:0]  check;
  logic               emit_go;
  logic [2:0]         par_idx;
  logic [GroupW-1:0]  group;

  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // register write; the user must write it only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
    end else if (cfg_valid_i) begin
      mask_q <= cfg_left_parity_mask_i;
    end
  end

  ean13_bcd_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .value_i  (raw_number_i),
    .done_o   (conv_done),
    .digits_o (conv_digits)
  );

  ean13_digit_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ring_ctrl),
    .digits_i (conv_digits),
    .head_o   (head),
    .check_o  (check)
  );

  // a group may be loaded when the output register is free or draining
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // left digit k = step-1 uses mask bit 5-k = 6-step
  assign par_idx = 3'(StepLeftHi - step_q);

  // group for the current emit step
  always_comb begin
    if (step_q == StepStart || step_q == StepEnd) begin
      group = GuardEdge;
    end else if (step_q == StepCentre) begin
      group = GuardCentre;
    end else if (step_q == StepCheck) begin
      group = code_l(check) ^ RInvert;
    end else if (step_q < StepCentre) begin
      group = mask_q[par_idx] ? code_g(head) : code_l(head);
    end else begin
      group = code_l(head) ^ RInvert;
    end
  end

  // next state and step counter
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) begin
          state_d = ST_CHECK;
          step_d  = '0;
        end
      end
      ST_CHECK: begin
        step_d = step_q + 1'b1;
        if (step_q == StepLastDigit) begin
          state_d = ST_EMIT;
          step_d  = '0;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          step_d = step_q + 1'b1;
          if (step_q == StepEnd) begin
            state_d = ST_IDLE;
            step_d  = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ring control and output register
  always_comb begin
    ring_ctrl   = '0;
    out_valid_d = out_valid_q && out_stall_i;
    modules_d   = modules_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_CONV: begin
        ring_ctrl.load = conv_done;
      end
      ST_CHECK: begin
        // one full turn leaves n1 at the head again
        ring_ctrl.rotate = 1'b1;
        ring_ctrl.accum  = 1'b1;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          modules_d   = group;
          // start guard drops n1 past the head; the centre guard, the check
          // digit and the end guard leave the ring alone
          ring_ctrl.rotate = (step_q != StepCentre) && (step_q != StepCheck) &&
                             (step_q != StepEnd);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    modules_q <= modules_d;
  end

  assign out_valid_o = out_valid_q;
  assign modules_o   = modules_q;

endmodule
